[sv/biq_pkg.sv]
// Shared widths, register indexes and types of the biquad filter.
package biq_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int COEF_W    = 18;
	localparam int COEF_FRAC = COEF_W - 2;
	localparam int PROD_W    = SAMPLE_W + COEF_W;
	localparam int FF_W      = PROD_W + 2;
	localparam int ACC_W     = PROD_W + 3;
	localparam int Q_W       = ACC_W - COEF_FRAC;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_B0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_B2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_A1 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_A2 = 3'd4;

	localparam logic signed [COEF_W-1:0] COEF_ONE = {2'b01, {COEF_FRAC{1'b0}}};
	localparam logic signed [COEF_W-1:0] COEF_ZERO = '0;
	localparam logic signed [ACC_W-1:0] ROUND_HALF = {{(ACC_W-COEF_FRAC){1'b0}}, 1'b1,
		{(COEF_FRAC-1){1'b0}}};
	localparam logic signed [SAMPLE_W-1:0] SMAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic signed [SAMPLE_W-1:0] SMIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

	typedef struct packed {
		logic signed [COEF_W-1:0] b0;
		logic signed [COEF_W-1:0] b1;
		logic signed [COEF_W-1:0] b2;
		logic signed [COEF_W-1:0] a1;
		logic signed [COEF_W-1:0] a2;
	} coef_t;

	typedef struct packed {
		logic                       valid;
		logic signed [SAMPLE_W-1:0] sample;
	} item_t;

endpackage

[sv/biq_if.sv]
// Stream interfaces for input samples and filtered results.
interface biq_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [biq_pkg::SAMPLE_W-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

interface biq_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [biq_pkg::SAMPLE_W-1:0] sample_out;
	logic                                clipped;

	modport source (output valid, output sample_out, output clipped, input ready);
	modport sink (input valid, input sample_out, input clipped, output ready);
endinterface

[sv/biq_front.sv]
// Input side: two-entry sample queue that decouples the stream from the datapath.
module biq_front (
	input  logic                  clk,
	input  logic                  arst_n,
	biq_in_if.sink                in_ch,
	output biq_pkg::item_t        item,
	input  logic                  pop
);

	logic signed [biq_pkg::SAMPLE_W-1:0] mem_q [2];
	logic                                wr_ptr_q;
	logic                                rd_ptr_q;
	logic [1:0]                          count_q;
	logic                                push;
	logic                                do_pop;

	assign in_ch.ready = (count_q != 2'd2);
	assign push        = in_ch.valid && in_ch.ready;
	assign do_pop      = pop && (count_q != 2'd0);

	assign item.valid  = (count_q != 2'd0);
	assign item.sample = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_ch.sample_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[sv/biq_back.sv]
// Datapath: feed-forward stage, feedback with round and saturate, output register.
module biq_back (
	input  logic           clk,
	input  logic           arst_n,
	input  biq_pkg::coef_t coef,
	input  biq_pkg::item_t item,
	output logic           pop,
	biq_out_if.source      out_ch
);

	logic signed [biq_pkg::SAMPLE_W-1:0] x1_q;
	logic signed [biq_pkg::SAMPLE_W-1:0] x2_q;
	logic signed [biq_pkg::SAMPLE_W-1:0] y1_q;
	logic signed [biq_pkg::SAMPLE_W-1:0] y2_q;
	logic signed [biq_pkg::FF_W-1:0]     ff_s1;
	logic                                valid_s1;
	logic                                out_valid_q;
	logic signed [biq_pkg::SAMPLE_W-1:0] out_sample_q;
	logic                                out_clip_q;

	logic signed [biq_pkg::PROD_W-1:0]   p_b0;
	logic signed [biq_pkg::PROD_W-1:0]   p_b1;
	logic signed [biq_pkg::PROD_W-1:0]   p_b2;
	logic signed [biq_pkg::PROD_W-1:0]   p_a1;
	logic signed [biq_pkg::PROD_W-1:0]   p_a2;
	logic signed [biq_pkg::FF_W-1:0]     ff_sum;
	logic signed [biq_pkg::ACC_W-1:0]    acc;
	logic signed [biq_pkg::Q_W-1:0]      q;
	logic                                over;
	logic signed [biq_pkg::SAMPLE_W-1:0] res;
	logic                                adv_s2;
	logic                                take;

	assign adv_s2 = valid_s1 && (!out_valid_q || out_ch.ready);
	assign take   = item.valid && (!valid_s1 || adv_s2);
	assign pop    = take;

	assign p_b0   = item.sample * coef.b0;
	assign p_b1   = x1_q * coef.b1;
	assign p_b2   = x2_q * coef.b2;
	assign ff_sum = biq_pkg::FF_W'(p_b0) + biq_pkg::FF_W'(p_b1) + biq_pkg::FF_W'(p_b2);

	assign p_a1 = y1_q * coef.a1;
	assign p_a2 = y2_q * coef.a2;
	assign acc  = biq_pkg::ACC_W'(ff_s1) - biq_pkg::ACC_W'(p_a1) - biq_pkg::ACC_W'(p_a2)
		+ biq_pkg::ROUND_HALF;
	assign q    = acc[biq_pkg::ACC_W-1:biq_pkg::COEF_FRAC];

	always_comb begin
		over = (q[biq_pkg::Q_W-1:biq_pkg::SAMPLE_W-1] != '0)
			&& (q[biq_pkg::Q_W-1:biq_pkg::SAMPLE_W-1] != '1);
		if (!over) begin
			res = q[biq_pkg::SAMPLE_W-1:0];
		end else if (q[biq_pkg::Q_W-1]) begin
			res = biq_pkg::SMIN;
		end else begin
			res = biq_pkg::SMAX;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ff_s1 <= ff_sum;
		end
		if (adv_s2) begin
			out_sample_q <= res;
			out_clip_q   <= over;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x1_q        <= '0;
			x2_q        <= '0;
			y1_q        <= '0;
			y2_q        <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				x1_q <= item.sample;
				x2_q <= x1_q;
			end
			if (adv_s2) begin
				y1_q <= res;
				y2_q <= y1_q;
			end
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (adv_s2) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s2) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.sample_out = out_sample_q;
	assign out_ch.clipped    = out_clip_q;

endmodule

[sv/biquad_iir_filter.sv]
// Direct-form-I biquad filter top level with coefficient registers.
// Path: a taken input word passes the queue, then the feed-forward register, then the output
// register; a low out_ch.ready stalls the last two. Throughput: one sample per cycle unless
// out_ch.ready stalls; the feedback multiply-add-saturate loop closes through y1_q alone.
// Reset clears sample and output history, the queue and all valid flags.
// Reset sets b0 to 1.0 and the other coefficients to zero.
module biquad_iir_filter (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [biq_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [biq_pkg::COEF_W-1:0]          cfg_data,
	biq_in_if.sink                              in_ch,
	biq_out_if.source                           out_ch
);

	biq_pkg::coef_t coef_q;
	biq_pkg::item_t item;
	logic           pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.b0 <= biq_pkg::COEF_ONE;
			coef_q.b1 <= biq_pkg::COEF_ZERO;
			coef_q.b2 <= biq_pkg::COEF_ZERO;
			coef_q.a1 <= biq_pkg::COEF_ZERO;
			coef_q.a2 <= biq_pkg::COEF_ZERO;
		end else if (cfg_we) begin
			case (cfg_index)
				biq_pkg::REG_B0: coef_q.b0 <= cfg_data;
				biq_pkg::REG_B1: coef_q.b1 <= cfg_data;
				biq_pkg::REG_B2: coef_q.b2 <= cfg_data;
				biq_pkg::REG_A1: coef_q.a1 <= cfg_data;
				biq_pkg::REG_A2: coef_q.a2 <= cfg_data;
				default:         coef_q    <= coef_q;
			endcase
		end
	end

	biq_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.item   (item),
		.pop    (pop)
	);

	biq_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.coef   (coef_q),
		.item   (item),
		.pop    (pop),
		.out_ch (out_ch)
	);

endmodule

[sim/testbench.sv]
// Testbench for the biquad filter: tabled and random samples checked against a bit-exact predictor.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import biq_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam logic signed [COEF_W-1:0] GAIN_MAX = {1'b0, {(COEF_W-1){1'b1}}};
	localparam logic signed [COEF_W-1:0] GAIN_MIN = {1'b1, {(COEF_W-1){1'b0}}};
	localparam int NUM_GAINS    = 5;
	localparam int QUIET_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASES       = 6;
	localparam int PHASE_WORDS  = 125;

	typedef enum int {GAIN_TOP, GAIN_BOTTOM, GAIN_GENTLE, GAIN_WILD} gain_style_e;

	typedef struct {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       clip;
	} filt_out_t;

	typedef struct {
		bit                         is_write;
		logic [CFG_IDX_W-1:0]       idx;
		logic [COEF_W-1:0]          data;
		logic signed [SAMPLE_W-1:0] x;
		bit                         pinned;
		logic signed [SAMPLE_W-1:0] want;
		bit                         want_clip;
	} step_t;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       cfg_we;
	logic [CFG_IDX_W-1:0]       cfg_index;
	logic [COEF_W-1:0]          cfg_data;
	logic                       pin_on;
	logic signed [SAMPLE_W-1:0] pin_sample;
	logic                       pin_clip;
	bit                         steady_send = 1'b0;
	int                         mismatches = 0;
	int                         quiet_cycles = 0;

	logic signed [COEF_W-1:0]   gain [NUM_GAINS];
	logic signed [SAMPLE_W-1:0] x_d1, x_d2, y_d1, y_d2;
	filt_out_t                  pending_out [$];
	step_t                      script [$];
	gain_style_e                phase_style [PHASES] = '{GAIN_TOP, GAIN_BOTTOM, GAIN_GENTLE,
		GAIN_WILD, GAIN_GENTLE, GAIN_WILD};

	biq_in_if  in_ch();
	biq_out_if out_ch();

	biquad_iir_filter u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic filt_out_t filter_step(input logic signed [SAMPLE_W-1:0] x);
		longint    acc;
		longint    q;
		filt_out_t r;
		acc = longint'(x) * longint'(gain[REG_B0])
			+ longint'(x_d1) * longint'(gain[REG_B1])
			+ longint'(x_d2) * longint'(gain[REG_B2])
			- longint'(y_d1) * longint'(gain[REG_A1])
			- longint'(y_d2) * longint'(gain[REG_A2]);
		q = (acc + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
		r.clip = 1'b1;
		if (q > longint'(SMAX)) begin
			r.sample = SMAX;
		end else if (q < longint'(SMIN)) begin
			r.sample = SMIN;
		end else begin
			r.sample = q[SAMPLE_W-1:0];
			r.clip = 1'b0;
		end
		x_d2 = x_d1;
		x_d1 = x;
		y_d2 = y_d1;
		y_d1 = r.sample;
		return r;
	endfunction

	function automatic int idle_span();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80) begin
			return $urandom_range(1, 3);
		end
		if (r < 96) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			return SAMPLE_W'($urandom);
		end
		if (r < 85) begin
			case ($urandom_range(0, 3))
				0: return SMAX;
				1: return SMIN;
				2: return '0;
				default: return -1;
			endcase
		end
		return SAMPLE_W'(int'($urandom_range(0, 511)) - 256);
	endfunction

	function automatic logic [COEF_W-1:0] pick_gain(input gain_style_e style);
		case (style)
			GAIN_TOP: return GAIN_MAX;
			GAIN_BOTTOM: return GAIN_MIN;
			GAIN_GENTLE: return COEF_W'(int'($urandom_range(0, 40000)) - 20000);
			default: return COEF_W'($urandom);
		endcase
	endfunction

	function automatic step_t tune_row(input logic [CFG_IDX_W-1:0] idx,
			input logic [COEF_W-1:0] data);
		step_t r;
		r.is_write = 1'b1;
		r.idx = idx;
		r.data = data;
		r.x = '0;
		r.pinned = 1'b0;
		r.want = '0;
		r.want_clip = 1'b0;
		return r;
	endfunction

	function automatic step_t known_row(input logic signed [SAMPLE_W-1:0] x,
			input logic signed [SAMPLE_W-1:0] want, input bit want_clip);
		step_t r;
		r.is_write = 1'b0;
		r.idx = REG_B0;
		r.data = '0;
		r.x = x;
		r.pinned = 1'b1;
		r.want = want;
		r.want_clip = want_clip;
		return r;
	endfunction

	function automatic step_t plain_row(input logic signed [SAMPLE_W-1:0] x);
		step_t r;
		r = known_row(x, '0, 1'b0);
		r.pinned = 1'b0;
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= 40) begin
			$display("mismatch at %0t: %s", $time, what);
		end
	endtask

	task automatic push_sample(input logic signed [SAMPLE_W-1:0] x, input bit pinned,
			input logic signed [SAMPLE_W-1:0] want, input bit want_clip, input bit more);
		int gap;
		in_ch.valid <= 1'b1;
		in_ch.sample_in <= x;
		pin_on <= pinned;
		pin_sample <= want;
		pin_clip <= want_clip;
		do @(posedge clk); while (!in_ch.ready);
		gap = (steady_send || $urandom_range(0, 99) < 55) ? 0 : idle_span();
		if (!more || gap > 0) begin
			in_ch.valid <= 1'b0;
		end
		repeat (gap) @(posedge clk);
	endtask

	task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data,
			input bit more);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		if (!more) begin
			cfg_we <= 1'b0;
		end
	endtask

	task automatic settle_filter();
		do @(posedge clk); while (pending_out.size() != 0);
	endtask

	always @(posedge clk) begin : score
		filt_out_t want;
		filt_out_t seen;
		bit        moved;
		moved = 1'b0;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				moved = 1'b1;
				if (pending_out.size() == 0) begin
					report_mismatch($sformatf("unexpected word %0d", out_ch.sample_out));
				end else begin
					want = pending_out.pop_front();
					if (out_ch.sample_out !== want.sample) begin
						report_mismatch($sformatf("sample_out %0d, want %0d",
							out_ch.sample_out, want.sample));
					end
					if (out_ch.clipped !== want.clip) begin
						report_mismatch($sformatf("clipped %b, want %b (sample %0d)",
							out_ch.clipped, want.clip, want.sample));
					end
				end
			end
			if (cfg_we && cfg_index <= REG_A2) begin
				gain[cfg_index] = cfg_data;
			end
			if (in_ch.valid && in_ch.ready) begin
				moved = 1'b1;
				seen = filter_step(in_ch.sample_in);
				if (pin_on) begin
					seen.sample = pin_sample;
					seen.clip = pin_clip;
				end
				pending_out.push_back(seen);
			end
		end
		quiet_cycles = moved ? 0 : quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin : result_sink
		int hold;
		int calm;
		int r;
		out_ch.ready <= 1'b0;
		hold = 0;
		calm = 0;
		forever begin
			@(posedge clk);
			r = $urandom_range(0, 99);
			if (calm > 0) begin
				calm--;
				out_ch.ready <= 1'b1;
			end else if (hold > 0) begin
				hold--;
				out_ch.ready <= 1'b0;
			end else if (r < 2) begin
				calm = $urandom_range(40, 200);
				out_ch.ready <= 1'b1;
			end else if (r < 25) begin
				hold = idle_span() - 1;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		bit          more;
		int          pause_at;
		gain_style_e style;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_B0;
		cfg_data <= '0;
		in_ch.valid <= 1'b0;
		in_ch.sample_in <= '0;
		pin_on <= 1'b0;
		pin_sample <= '0;
		pin_clip <= 1'b0;
		gain[REG_B0] = COEF_ONE;
		gain[REG_B1] = COEF_ZERO;
		gain[REG_B2] = COEF_ZERO;
		gain[REG_A1] = COEF_ZERO;
		gain[REG_A2] = COEF_ZERO;
		x_d1 = '0;
		x_d2 = '0;
		y_d1 = '0;
		y_d2 = '0;

		// unity gain after reset
		script.push_back(known_row(0, 0, 1'b0));
		script.push_back(known_row(SMAX, SMAX, 1'b0));
		script.push_back(known_row(SMIN, SMIN, 1'b0));
		script.push_back(known_row(1, 1, 1'b0));
		script.push_back(known_row(-1, -1, 1'b0));
		// largest gain saturates both ways; spare index must not alias b0
		script.push_back(tune_row(REG_B0, GAIN_MAX));
		script.push_back(tune_row(REG_SPARE_LO, '0));
		script.push_back(known_row(SMAX, SMAX, 1'b1));
		script.push_back(known_row(SMIN, SMIN, 1'b1));
		script.push_back(known_row(0, 0, 1'b0));
		script.push_back(tune_row(REG_B0, GAIN_MIN));
		script.push_back(known_row(SMIN, SMAX, 1'b1));
		script.push_back(known_row(SMAX, SMIN, 1'b1));
		// half gain: exact halves round up
		script.push_back(tune_row(REG_B0, COEF_ONE >>> 1));
		script.push_back(known_row(1, 1, 1'b0));
		script.push_back(known_row(-1, 0, 1'b0));
		script.push_back(known_row(3, 2, 1'b0));
		script.push_back(known_row(-3, -1, 1'b0));
		script.push_back(tune_row(REG_B0, COEF_ONE));
		script.push_back(tune_row(REG_B1, GAIN_MAX));
		script.push_back(tune_row(REG_B2, GAIN_MIN));
		script.push_back(tune_row(REG_A1, GAIN_MAX));
		script.push_back(tune_row(REG_A2, GAIN_MIN));
		script.push_back(tune_row(REG_SPARE_HI, '1));
		script.push_back(plain_row(SMAX));
		script.push_back(plain_row(SMIN));
		script.push_back(plain_row(SMAX));
		script.push_back(plain_row(0));
		script.push_back(plain_row(-1));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			more = (i + 1 < script.size()) && (script[i + 1].is_write == script[i].is_write);
			if (script[i].is_write) begin
				if (i > 0 && !script[i - 1].is_write) begin
					settle_filter();
				end
				reg_write(script[i].idx, script[i].data, more);
			end else begin
				push_sample(script[i].x, script[i].pinned, script[i].want,
					script[i].want_clip, more);
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			settle_filter();
			steady_send = (p == 3);
			for (int r = 0; r < NUM_GAINS; r++) begin
				style = (p == PHASES - 1) ? gain_style_e'($urandom_range(0, 3)) : phase_style[p];
				reg_write(REG_B0 + CFG_IDX_W'(r), pick_gain(style), 1'b1);
			end
			reg_write(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
				COEF_W'($urandom), 1'b0);
			pause_at = $urandom_range(10, PHASE_WORDS - 10);
			for (int i = 0; i < PHASE_WORDS; i++) begin
				more = (i != pause_at) && (i != PHASE_WORDS - 1);
				push_sample(pick_sample(), 1'b0, '0, 1'b0, more);
				// hold the sender until the filter has emptied
				if (i == pause_at) begin
					settle_filter();
				end
			end
		end

		settle_filter();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_out.size() != 0) begin
			report_mismatch($sformatf("%0d results never arrived", pending_out.size()));
		end
		if (mismatches == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

[sim.f]
sv/biq_pkg.sv
sv/biq_if.sv
sv/biq_front.sv
sv/biq_back.sv
sv/biquad_iir_filter.sv
sim/testbench.sv
